// ===== hdl/ring_buffer_deque_top_macros.svh =====
// Assertion helpers for the deque top level.
`ifndef RING_BUFFER_DEQUE_TOP_MACROS_SVH
`define RING_BUFFER_DEQUE_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define RBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rbd_pkg.sv =====
package rbd_pkg;

    // Request and result field widths
    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int TOTAL_W     = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Result payload, packed in the same order as the output tdata
    typedef struct packed {
        logic                     is_empty;
        logic [TOTAL_W-1:0]       entry_total;
        logic signed [VALUE_W-1:0] read_value;
    } rbd_result_t;

endpackage

// ===== hdl/ring_buffer_deque_top.sv =====
// Push, no-op and rejected requests give their result straight from the result register;
//   pop and peek pass through the registered store read first, then the result register.
// Pushes and rejects: 1 request per cycle while the result channel is not stalled;
//   pop/peek block new requests until their store read data, from the single read port, has arrived.
// Reset (rst_n, async, active low): count zero, both pointers at DEPTH/2, no result held.
//   The entry store is not cleared; only held entries are ever read.
`include "ring_buffer_deque_top_macros.svh"

module ring_buffer_deque_top #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] push_value
    input  logic [rbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] action
    input  logic [rbd_pkg::ACTION_W-1:0]      s_axis_tuser,
    // Result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_value, [42:32] entry_total, [43] is_empty, [47:44] zero
    output logic [rbd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [rbd_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import rbd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(DEPTH / 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;

    // Sequencer: idle, or waiting for the store read data
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                     state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic                     m_valid_reg, m_valid_next;
    rbd_result_t              result_reg, result_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    // Entry store, one write and one registered read port
    logic [DATA_WIDTH-1:0]    entry_store [DEPTH];
    logic [DATA_WIDTH-1:0]    rd_data_reg;

    logic                     accept;
    logic [ACTION_W-1:0]      action;
    logic signed [VALUE_W-1:0] push_value;
    logic [DATA_WIDTH-1:0]    wr_data;
    logic [PTR_W-1:0]         head_inc, head_dec, tail_inc, tail_dec;

    // Decoded effect of the current request, before gating with accept
    logic [PTR_W-1:0]         dec_head, dec_tail;
    logic [CNT_W-1:0]         dec_count;
    logic [STATUS_W-1:0]      dec_status;
    logic                     dec_we, dec_re;
    logic [PTR_W-1:0]         dec_waddr, dec_raddr;

    logic                     store_full, store_empty;
    logic [PTR_W-1:0]         ptr_gap;
    logic [PTR_W-1:0]         count_mod;

    assign action     = s_axis_tuser;
    assign push_value = s_axis_tdata[VALUE_W-1:0];
    // Keep the low DATA_WIDTH bits of the request, zero filled when the store is wider
    assign wr_data    = DATA_WIDTH'($unsigned(push_value));

    // Take a new request only between items and when the result slot frees up
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign store_full  = (count_reg == CNT_FULL);
    assign store_empty = (count_reg == CNT_ZERO);

    // Ring pointer neighbors, wrapping at DEPTH (not necessarily a power of two)
    assign head_inc = (head_reg == PTR_LAST) ? '0 : PTR_W'(head_reg + 1'b1);
    assign head_dec = (head_reg == '0) ? PTR_LAST : PTR_W'(head_reg - 1'b1);
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : PTR_W'(tail_reg + 1'b1);
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : PTR_W'(tail_reg - 1'b1);

    // Decode the request into pointer, count and store port actions
    always_comb
    begin
        dec_head   = head_reg;
        dec_tail   = tail_reg;
        dec_count  = count_reg;
        dec_status = ST_OK;
        dec_we     = 1'b0;
        dec_re     = 1'b0;
        dec_waddr  = tail_reg;
        dec_raddr  = head_reg;
        case (action)
            ACT_PUSH_FRONT:
            begin
                if (store_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    // step the front back, then write the new front entry
                    dec_head  = head_dec;
                    dec_we    = 1'b1;
                    dec_waddr = head_dec;
                    dec_count = CNT_W'(count_reg + 1'b1);
                end
            end
            ACT_PUSH_BACK:
            begin
                if (store_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_we    = 1'b1;
                    dec_waddr = tail_reg;
                    dec_tail  = tail_inc;
                    dec_count = CNT_W'(count_reg + 1'b1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (store_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_re    = 1'b1;
                    dec_raddr = head_reg;
                    dec_head  = head_inc;
                    dec_count = CNT_W'(count_reg - 1'b1);
                end
            end
            ACT_POP_BACK:
            begin
                if (store_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_re    = 1'b1;
                    dec_raddr = tail_dec;
                    dec_tail  = tail_dec;
                    dec_count = CNT_W'(count_reg - 1'b1);
                end
            end
            ACT_PEEK_FRONT:
            begin
                if (store_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_re    = 1'b1;
                    dec_raddr = head_reg;
                end
            end
            ACT_PEEK_BACK:
            begin
                if (store_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_re    = 1'b1;
                    dec_raddr = tail_dec;
                end
            end
            default:
            begin
                // unused action codes: no operation, report the count as is
            end
        endcase
    end

    // Commit the request, fill the result slot and sequence the read wait
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        status_next  = status_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    head_next               = dec_head;
                    tail_next               = dec_tail;
                    count_next              = dec_count;
                    status_next             = dec_status;
                    result_next.read_value  = '0;
                    result_next.entry_total = TOTAL_W'(dec_count);
                    result_next.is_empty    = (dec_count == CNT_ZERO);
                    if (dec_re)
                    begin
                        // hold the result back until the store data arrives
                        m_valid_next = 1'b0;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                result_next.read_value = VALUE_W'(rd_data_reg);
                m_valid_next           = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= PTR_HALF;
            tail_reg    <= PTR_HALF;
            count_reg   <= CNT_ZERO;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // Entry store: a request either writes or reads, and a read always follows
    // the write of an earlier request, so no same-address overlap occurs.
    always_ff @(posedge clk)
    begin
        if (accept && dec_we)
        begin
            entry_store[dec_waddr] <= wr_data;
        end
        if (accept && dec_re)
        begin
            rd_data_reg <= entry_store[dec_raddr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(result_reg);
    assign m_axis_tuser  = status_reg;

    // Distance from head to tail around the ring, for the pointer check
    assign ptr_gap   = (tail_reg >= head_reg) ? PTR_W'(tail_reg - head_reg)
                                              : PTR_W'(tail_reg + PTR_LAST - head_reg + 1'b1);
    assign count_mod = store_full ? '0 : PTR_W'(count_reg);

    `RBD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_FULL,
        "entry count beyond store depth")
    `RBD_ASSERT_NOW(a_ptr_gap, 1'b1, ptr_gap == count_mod,
        "head and tail pointers disagree with the entry count")
    `RBD_ASSERT_NOW(a_read_slot_free, state_reg == S_READ, !m_valid_reg,
        "result slot occupied while store read data is due")
    `RBD_ASSERT_NEXT(a_read_follows, accept && dec_re, state_reg == S_READ && !s_axis_tready,
        "pop or peek did not wait for the store read")

endmodule
